// ===== sv/tin_pkg.sv =====
package tin_pkg;

   localparam logic [7:0] B_IAC  = 8'hff;
   localparam logic [7:0] B_DONT = 8'd254;
   localparam logic [7:0] B_DO   = 8'd253;
   localparam logic [7:0] B_WONT = 8'd252;
   localparam logic [7:0] B_WILL = 8'd251;
   localparam logic [7:0] B_SB   = 8'd250;
   localparam logic [7:0] B_SE   = 8'd240;

   localparam logic [7:0] OPT_ECHO  = 8'd1;
   localparam logic [7:0] OPT_SGA   = 8'd3;
   localparam logic [7:0] OPT_TTYPE = 8'd24;
   localparam logic [7:0] OPT_NAWS  = 8'd31;
   localparam logic [7:0] TT_IS     = 8'd0;

   localparam int unsigned TERM_TYPE_MAX = 8;
   localparam int unsigned QUEUE_DEPTH   = 4;

   localparam logic [1:0] CSR_COLUMNS  = 2'd0;
   localparam logic [1:0] CSR_ROWS     = 2'd1;
   localparam logic [1:0] CSR_TT_CHARS = 2'd2;
   localparam logic [1:0] CSR_TT_LEN   = 2'd3;

   typedef enum logic [1:0] {
      JOB_PASS  = 2'd0,
      JOB_REPLY = 2'd1,
      JOB_NAWS  = 2'd2,
      JOB_TTYPE = 2'd3
   } job_kind_type;

   // b0: passed byte or option, b1: reply verb
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   b0;
      logic [7:0]   b1;
   } job_type;

endpackage

// ===== sv/tin_front.sv =====
module tin_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [7:0]       in_byte,
   input  logic             q_full,
   output logic             in_stall,
   output logic             job_valid,
   output tin_pkg::job_type job
);
   import tin_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_IAC  = 2'd1;
   localparam logic [1:0] PH_OPT  = 2'd2;
   localparam logic [1:0] PH_SUB  = 2'd3;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] verb_ff, verb_in;
   logic [7:0] sub_ff, sub_in;
   logic       seen_ff, seen_in;
   logic       accept;

   assign in_stall = q_full;
   assign accept   = in_valid && !q_full;

   always_comb begin
      phase_in  = phase_ff;
      verb_in   = verb_ff;
      sub_in    = sub_ff;
      seen_in   = seen_ff;
      job_valid = 1'b0;
      job.kind  = JOB_PASS;
      job.b0    = in_byte;
      job.b1    = B_IAC;
      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (in_byte == B_IAC) begin
                  phase_in = PH_IAC;
               end else begin
                  job_valid = 1'b1;
               end
            end
            PH_IAC: begin
               if (in_byte == B_WILL || in_byte == B_WONT ||
                   in_byte == B_DO || in_byte == B_DONT) begin
                  verb_in  = in_byte;
                  phase_in = PH_OPT;
               end else if (in_byte == B_SB) begin
                  verb_in  = in_byte;
                  sub_in   = 8'd0;
                  seen_in  = 1'b0;
                  phase_in = PH_SUB;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_OPT: begin
               if (verb_ff == B_WILL) begin
                  job_valid = 1'b1;
                  job.kind  = JOB_REPLY;
                  job.b1    = (in_byte == OPT_ECHO || in_byte == OPT_SGA) ? B_DO : B_DONT;
               end else if (verb_ff == B_DO) begin
                  job_valid = 1'b1;
                  if (in_byte == OPT_NAWS) begin
                     job.kind = JOB_NAWS;
                  end else begin
                     job.kind = JOB_REPLY;
                     job.b1   = (in_byte == OPT_TTYPE) ? B_WILL : B_WONT;
                  end
               end
               phase_in = PH_IDLE;
            end
            PH_SUB: begin
               if (in_byte == B_SE) begin
                  if (seen_ff && sub_ff == OPT_TTYPE) begin
                     job_valid = 1'b1;
                     job.kind  = JOB_TTYPE;
                  end
                  phase_in = PH_IDLE;
                  seen_in  = 1'b0;
               end else if (!seen_ff) begin
                  sub_in  = in_byte;
                  seen_in = 1'b1;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         verb_ff  <= 8'd0;
         sub_ff   <= 8'd0;
         seen_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         verb_ff  <= verb_in;
         sub_ff   <= sub_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

// ===== sv/tin_queue.sv =====
module tin_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tin_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             nonempty,
   output tin_pkg::job_type head
);
   import tin_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign head     = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/tin_back.sv =====
module tin_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  tin_pkg::job_type job,
   output logic             job_pop,
   input  logic [15:0]      columns,
   input  logic [15:0]      rows,
   input  logic [63:0]      tt_chars,
   input  logic [3:0]       tt_len,
   output logic             out_valid,
   input  logic             out_stall,
   output logic [7:0]       out_byte,
   output logic             out_to_terminal,
   output logic             out_last
);
   import tin_pkg::*;

   logic [3:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       term_ff, term_in;
   logic       last_ff, last_in;
   logic       fire;
   logic [3:0] len_clip;
   logic [3:0] total;
   logic [3:0] char_off;
   logic [7:0] sel_byte;

   assign len_clip = (tt_len > 4'(TERM_TYPE_MAX)) ? 4'(TERM_TYPE_MAX) : tt_len;
   assign char_off = idx_ff - 4'd4;
   assign fire     = job_valid && (!valid_ff || !out_stall);

   always_comb begin
      unique case (job.kind)
         JOB_PASS:  total = 4'd1;
         JOB_REPLY: total = 4'd3;
         JOB_NAWS:  total = 4'd12;
         JOB_TTYPE: total = 4'd6 + len_clip;
         default:   total = 4'd1;
      endcase
   end

   always_comb begin
      sel_byte = B_IAC;
      unique case (job.kind)
         JOB_PASS: sel_byte = job.b0;
         JOB_REPLY: begin
            unique case (idx_ff)
               4'd1:    sel_byte = job.b1;
               4'd2:    sel_byte = job.b0;
               default: sel_byte = B_IAC;
            endcase
         end
         JOB_NAWS: begin
            unique case (idx_ff)
               4'd1:    sel_byte = B_WILL;
               4'd2:    sel_byte = OPT_NAWS;
               4'd4:    sel_byte = B_SB;
               4'd5:    sel_byte = OPT_NAWS;
               4'd6:    sel_byte = columns[15:8];
               4'd7:    sel_byte = columns[7:0];
               4'd8:    sel_byte = rows[15:8];
               4'd9:    sel_byte = rows[7:0];
               4'd11:   sel_byte = B_SE;
               default: sel_byte = B_IAC;
            endcase
         end
         JOB_TTYPE: begin
            priority if (idx_ff == 4'd0) begin
               sel_byte = B_IAC;
            end else if (idx_ff == 4'd1) begin
               sel_byte = B_SB;
            end else if (idx_ff == 4'd2) begin
               sel_byte = OPT_TTYPE;
            end else if (idx_ff == 4'd3) begin
               sel_byte = TT_IS;
            end else if (char_off < len_clip) begin
               sel_byte = tt_chars[8*char_off[2:0] +: 8];
            end else if (char_off == len_clip) begin
               sel_byte = B_IAC;
            end else begin
               sel_byte = B_SE;
            end
         end
         default: sel_byte = B_IAC;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && out_stall;
      byte_in  = byte_ff;
      term_in  = term_ff;
      last_in  = last_ff;
      job_pop  = 1'b0;
      if (fire) begin
         valid_in = 1'b1;
         byte_in  = sel_byte;
         term_in  = (job.kind == JOB_PASS);
         last_in  = (idx_ff == total - 4'd1);
         // advance within the job, drop it after its final byte
         if (last_in) begin
            job_pop = 1'b1;
            idx_in  = 4'd0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      term_ff <= term_in;
      last_ff <= last_in;
   end

   assign out_valid       = valid_ff;
   assign out_byte        = byte_ff;
   assign out_to_terminal = term_ff;
   assign out_last        = last_ff;

endmodule

// ===== sv/telnet_iac_negotiator.sv =====
// With the back end idle, the first result of an item passes the queue write, then the output
// register.
// The front takes one received byte per cycle unless the queue is full. The back emits one
// result byte per cycle unless stalled; a pass-through is 1 byte, a type reply up to 14 bytes.
// A 4-entry job queue separates the two, so replies drain while bytes keep arriving.
// Reset (synchronous): parser idle, queue and output empty, registers at their defaults.
module telnet_iac_negotiator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_to_terminal,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import tin_pkg::*;

   logic [15:0] columns_ff;
   logic [15:0] rows_ff;
   logic [63:0] tt_chars_ff;
   logic [3:0]  tt_len_ff;

   logic    q_full, q_nonempty, q_pop, front_valid;
   job_type front_job, head_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff  <= 16'd80;
         rows_ff     <= 16'd24;
         tt_chars_ff <= 64'd0;
         tt_len_ff   <= 4'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_COLUMNS:  columns_ff  <= csr_wdata[15:0];
            CSR_ROWS:     rows_ff     <= csr_wdata[15:0];
            CSR_TT_CHARS: tt_chars_ff <= csr_wdata;
            CSR_TT_LEN:   tt_len_ff   <= csr_wdata[3:0];
            default:      tt_len_ff   <= tt_len_ff;
         endcase
      end
   end

   tin_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_byte   (req_rx_byte),
      .q_full    (q_full),
      .in_stall  (req_stall),
      .job_valid (front_valid),
      .job       (front_job)
   );

   tin_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .push_job (front_job),
      .pop      (q_pop),
      .full     (q_full),
      .nonempty (q_nonempty),
      .head     (head_job)
   );

   tin_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (q_nonempty),
      .job             (head_job),
      .job_pop         (q_pop),
      .columns         (columns_ff),
      .rows            (rows_ff),
      .tt_chars        (tt_chars_ff),
      .tt_len          (tt_len_ff),
      .out_valid       (rsp_valid),
      .out_stall       (rsp_stall),
      .out_byte        (rsp_out_byte),
      .out_to_terminal (rsp_to_terminal),
      .out_last        (rsp_last)
   );

endmodule

// ===== dv/telnet_iac_negotiator_checker.sv =====
`timescale 1ns / 1ps

module telnet_iac_negotiator_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_to_terminal,
   input  logic        rsp_last,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output int          mismatches,
   output int          outstanding,
   output int          bytes_checked
);
   import tin_pkg::*;

   typedef enum logic [1:0] {
      P_IDLE   = 2'd0,
      P_CMD    = 2'd1,
      P_OPTION = 2'd2,
      P_SUBNEG = 2'd3
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       to_term;
      logic       last;
   } tx_byte_type;

   tx_byte_type     reply_q[$];
   tx_byte_type     got;
   tx_byte_type     want;

   logic [15:0]  cols_q;
   logic [15:0]  rows_q;
   logic [63:0]  tt_chars_q;
   logic [3:0]   tt_len_q;

   parse_phase_type phase;
   logic [7:0]   verb_q;
   logic [7:0]   sub_opt;
   logic         sub_seen;

   initial begin
      mismatches    = 0;
      outstanding   = 0;
      bytes_checked = 0;
   end

   task automatic report(input string msg);
      if (mismatches < 100)
         $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic tx_byte_type net_byte(input logic [7:0] b);
      return '{data: b, to_term: 1'b0, last: 1'b0};
   endfunction

   // Advance the parser by one received byte and queue the bytes it answers with.
   task automatic parse_byte(input logic [7:0] b);
      tx_byte_type reply[$];
      int       n;
      case (phase)
         P_IDLE: begin
            if (b == B_IAC)
               phase = P_CMD;
            else
               reply.push_back('{data: b, to_term: 1'b1, last: 1'b0});
         end
         P_CMD: begin
            if (b == B_WILL || b == B_WONT || b == B_DO || b == B_DONT) begin
               verb_q = b;
               phase  = P_OPTION;
            end else if (b == B_SB) begin
               verb_q   = b;
               sub_opt  = 8'd0;
               sub_seen = 1'b0;
               phase    = P_SUBNEG;
            end else begin
               // unknown command, second IAC included: drop
               phase = P_IDLE;
            end
         end
         P_OPTION: begin
            if (verb_q == B_WILL) begin
               reply.push_back(net_byte(B_IAC));
               reply.push_back(net_byte((b == OPT_ECHO || b == OPT_SGA) ? B_DO : B_DONT));
               reply.push_back(net_byte(b));
            end else if (verb_q == B_DO) begin
               reply.push_back(net_byte(B_IAC));
               reply.push_back(net_byte((b == OPT_TTYPE || b == OPT_NAWS) ? B_WILL : B_WONT));
               reply.push_back(net_byte(b));
               if (b == OPT_NAWS) begin
                  reply.push_back(net_byte(B_IAC));
                  reply.push_back(net_byte(B_SB));
                  reply.push_back(net_byte(OPT_NAWS));
                  reply.push_back(net_byte(cols_q[15:8]));
                  reply.push_back(net_byte(cols_q[7:0]));
                  reply.push_back(net_byte(rows_q[15:8]));
                  reply.push_back(net_byte(rows_q[7:0]));
                  reply.push_back(net_byte(B_IAC));
                  reply.push_back(net_byte(B_SE));
               end
            end
            phase = P_IDLE;
         end
         P_SUBNEG: begin
            if (b == B_SE) begin
               if (sub_seen && sub_opt == OPT_TTYPE) begin
                  n = (tt_len_q > TERM_TYPE_MAX) ? TERM_TYPE_MAX : tt_len_q;
                  reply.push_back(net_byte(B_IAC));
                  reply.push_back(net_byte(B_SB));
                  reply.push_back(net_byte(OPT_TTYPE));
                  reply.push_back(net_byte(TT_IS));
                  for (int i = 0; i < n; i++)
                     reply.push_back(net_byte(tt_chars_q[8*i +: 8]));
                  reply.push_back(net_byte(B_IAC));
                  reply.push_back(net_byte(B_SE));
               end
               phase    = P_IDLE;
               sub_seen = 1'b0;
            end else if (!sub_seen) begin
               sub_opt  = b;
               sub_seen = 1'b1;
            end
         end
      endcase
      if (reply.size() > 0)
         reply[reply.size() - 1].last = 1'b1;
      foreach (reply[i])
         reply_q.push_back(reply[i]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reply_q.delete();
         cols_q     = 16'd80;
         rows_q     = 16'd24;
         tt_chars_q = 64'd0;
         tt_len_q   = 4'd0;
         phase      = P_IDLE;
         verb_q     = 8'd0;
         sub_opt    = 8'd0;
         sub_seen   = 1'b0;
      end else begin
         // outputs leave a register, so a result never stems from this edge's input
         if (rsp_valid && !rsp_stall) begin
            got = '{data: rsp_out_byte, to_term: rsp_to_terminal, last: rsp_last};
            bytes_checked++;
            if (reply_q.size() == 0) begin
               report($sformatf("unexpected result byte %02h term %b last %b",
                                got.data, got.to_term, got.last));
            end else begin
               want = reply_q.pop_front();
               if (got !== want)
                  report($sformatf("got byte %02h term %b last %b, want %02h term %b last %b",
                                   got.data, got.to_term, got.last,
                                   want.data, want.to_term, want.last));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COLUMNS:  cols_q     = csr_wdata[15:0];
               CSR_ROWS:     rows_q     = csr_wdata[15:0];
               CSR_TT_CHARS: tt_chars_q = csr_wdata;
               CSR_TT_LEN:   tt_len_q   = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            parse_byte(req_rx_byte);
      end
      outstanding = reply_q.size();
   end

endmodule

// ===== dv/telnet_iac_negotiator_test.sv =====
`timescale 1ns / 1ps

module telnet_iac_negotiator_test;
   import tin_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_BYTES  = 38;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [7:0] CMD_NOP = 8'd241;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_stall = 1'b0;
   logic        csr_valid = 1'b0;
   logic [1:0]  csr_index = CSR_COLUMNS;
   logic [63:0] csr_wdata = 64'd0;

   logic        req_stall;
   logic        rsp_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_to_terminal;
   logic        rsp_last;
   logic        csr_ready;

   int          mismatches;
   int          outstanding;
   int          bytes_checked;

   int unsigned snd_idle_pct = 0;
   int unsigned rcv_idle_pct = 0;
   logic        hold_off = 1'b0;
   logic        hold_off_go = 1'b0;
   int          bytes_sent = 0;
   int          csr_writes = 0;
   int          cycles = 0;
   int          phase_start;

   logic [7:0] directed_bytes [25] = '{
      8'h00,
      B_IAC, B_IAC,
      B_IAC, B_WILL, OPT_ECHO,
      B_IAC, B_DO, OPT_NAWS,
      B_IAC, B_DO, OPT_TTYPE,
      B_IAC, B_DONT, OPT_SGA,
      B_IAC, B_SB, OPT_TTYPE, TT_IS, B_SE,
      B_IAC, B_SB, B_SE,
      B_IAC, CMD_NOP
   };

   telnet_iac_negotiator u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_to_terminal (rsp_to_terminal),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   telnet_iac_negotiator_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_to_terminal (rsp_to_terminal),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .bytes_checked   (bytes_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d result bytes still due", cycles, outstanding);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_stall <= hold_off || ($urandom_range(99) < rcv_idle_pct);

   // long receiver hold-off so the job queue fills and the input backs up
   initial begin
      wait (hold_off_go);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Write all four registers back to back; valid stays high across the transfers.
   task automatic write_regs(input logic [15:0] cols, input logic [15:0] rows,
                             input logic [63:0] chars, input logic [3:0] len);
      logic [63:0] vals [4];
      logic [1:0]  idx  [4];
      vals = '{{48'd0, cols}, {48'd0, rows}, chars, {60'd0, len}};
      idx  = '{CSR_COLUMNS, CSR_ROWS, CSR_TT_CHARS, CSR_TT_LEN};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
         csr_writes++;
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait for every predicted byte, then let trailing work finish.
   task automatic settle();
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_option();
      case ($urandom_range(5))
         0:       return OPT_ECHO;
         1:       return OPT_SGA;
         2:       return OPT_TTYPE;
         3:       return OPT_NAWS;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_sub_byte();
      logic [7:0] b;
      b = 8'($urandom);
      return (b == B_SE) ? 8'd0 : b;
   endfunction

   task automatic send_sequence();
      int unsigned kind;
      logic [7:0]  b;
      kind = $urandom_range(99);
      if (kind < 25) begin
         send_byte(8'($urandom_range(254)));
      end else if (kind < 55) begin
         send_byte(B_IAC);
         case ($urandom_range(3))
            0:       send_byte(B_WILL);
            1:       send_byte(B_WONT);
            2:       send_byte(B_DO);
            default: send_byte(B_DONT);
         endcase
         send_byte(pick_option());
      end else if (kind < 78) begin
         send_byte(B_IAC);
         send_byte(B_SB);
         if ($urandom_range(9) != 0) begin
            send_byte(($urandom_range(9) < 7) ? OPT_TTYPE : pick_sub_byte());
            repeat ($urandom_range(3))
               send_byte(pick_sub_byte());
         end
         send_byte(B_SE);
      end else if (kind < 88) begin
         // unknown command bytes, a second IAC among them
         b = 8'($urandom);
         if (b >= B_SB && b != B_IAC)
            b = B_IAC;
         send_byte(B_IAC);
         send_byte(b);
      end else begin
         repeat ($urandom_range(1, 3))
            send_byte(8'($urandom));
      end
   endtask

   task automatic run_random(input int unsigned snd_pct, input int unsigned rcv_pct);
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      phase_start  = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES)
         send_sequence();
      settle();
   endtask

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_regs(16'd132, 16'd43, 64'h0000_0030_3174_7376, 4'd5);
      foreach (directed_bytes[i])
         send_byte(directed_bytes[i]);
      settle();

      write_regs(16'h0000, 16'h0000, 64'd0, 4'd0);
      run_random(8, 67);

      write_regs(16'hffff, 16'hffff, {64{1'b1}}, 4'd8);
      run_random(67, 8);

      // overlong type length clips to the maximum
      write_regs(16'($urandom), 16'($urandom), {$urandom, $urandom}, 4'd15);
      hold_off_go = 1'b1;
      run_random(0, 0);

      write_regs(16'($urandom), 16'($urandom), {$urandom, $urandom},
                 4'($urandom_range(1, 7)));
      run_random(0, 0);

      $display("covered %0d received bytes and %0d register writes across five settings",
               bytes_sent, csr_writes);
      $display("checked %0d reply and pass-through bytes, with stalls and a long hold-off",
               bytes_checked);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
sv/tin_pkg.sv
sv/tin_front.sv
sv/tin_queue.sv
sv/tin_back.sv
sv/telnet_iac_negotiator.sv
dv/telnet_iac_negotiator_checker.sv
dv/telnet_iac_negotiator_test.sv
